[design/pps_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types, codes and default sizes of the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int MAX_TASKS_DEF = 16;
    localparam int TIME_BITS_DEF = 16;
    localparam int SLOT_BITS     = 4;
    localparam int PRIO_BITS     = 8;
    localparam int KIND_BITS     = 2;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [KIND_BITS-1:0] KIND_LOAD = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_RAN  = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_IDLE = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_DONE = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC,
        ST_FIN
    } pps_state_t;

endpackage
`default_nettype wire

[design/preemptive_priority_scheduler_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_top
// Task table in one synchronous memory; a tick scans it for the most urgent
// ready task, charges one unit of work to it and reports the outcome.
// ----------------------------------------------------------------------------
// Load: accepted in ST_IDLE, result loaded into the output register in ST_FIN.
// Tick: ST_SCAN walks the slots, reading one entry per cycle through the single
// memory read port, then ST_EXEC charges the chosen task and ST_FIN loads the result.
// A new transaction is accepted only back in ST_IDLE, after the result is loaded.
// Results wait in an output register; a stalled output holds the FSM in ST_FIN.
// Reset clears the valid bits, the time and all control state.
module preemptive_priority_scheduler_top #(
    parameter int MAX_TASKS = pps_pkg::MAX_TASKS_DEF,
    parameter int TIME_BITS = pps_pkg::TIME_BITS_DEF,
    localparam int S_DATA_W = ((pps_pkg::SLOT_BITS + 2 * TIME_BITS + pps_pkg::PRIO_BITS
                               + 7) / 8) * 8,
    localparam int M_DATA_W = ((pps_pkg::SLOT_BITS + 1 + 4 * TIME_BITS + 7) / 8) * 8
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // slot, arrival_time, burst_length, task_priority
    input  wire logic [S_DATA_W-1:0]            s_tdata,
    // opcode
    input  wire logic                           s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // chosen_slot, tick_start, finished, finish_time, turnaround, waiting
    output logic [M_DATA_W-1:0]                 m_tdata,
    // kind
    output logic [pps_pkg::KIND_BITS-1:0]       m_tuser
);

    import pps_pkg::*;

    localparam int SLOT_W = $clog2(MAX_TASKS);
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);
    localparam int ENT_W  = 3 * TIME_BITS + PRIO_BITS;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    pps_state_t state_reg, state_next;

    logic [ENT_W-1:0]     mem [MAX_TASKS];
    logic [ENT_W-1:0]     rd_data_reg;
    logic [SLOT_W-1:0]    rd_idx_reg;
    logic                 mem_we;
    logic [SLOT_W-1:0]    mem_waddr;
    logic [ENT_W-1:0]     mem_wdata;
    logic [SLOT_W-1:0]    mem_raddr;

    logic [MAX_TASKS-1:0] valid_reg;
    logic [TIME_BITS-1:0] time_reg;
    logic [CNT_W-1:0]     scan_cnt_reg;

    logic                 pending_reg;
    logic                 found_reg;
    logic [SLOT_W-1:0]    best_idx_reg;
    logic [PRIO_BITS-1:0] best_pri_reg;
    logic [TIME_BITS-1:0] best_arr_reg;
    logic [TIME_BITS-1:0] best_burst_reg;
    logic [TIME_BITS-1:0] best_rem_reg;

    logic [KIND_BITS-1:0] res_kind_reg;
    logic [SLOT_BITS-1:0] res_slot_reg;
    logic [TIME_BITS-1:0] res_tick_reg;
    logic                 res_fin_reg;
    logic [TIME_BITS-1:0] res_ct_reg;
    logic [TIME_BITS-1:0] res_tat_reg;

    logic                 m_tvalid_reg;
    logic [M_DATA_W-1:0]  m_tdata_reg;
    logic [KIND_BITS-1:0] m_tuser_reg;

    logic                 in_fire;
    logic                 out_load;
    logic                 scan_last;

    logic [SLOT_BITS-1:0] in_slot;
    logic [TIME_BITS-1:0] in_arr;
    logic [TIME_BITS-1:0] in_burst;
    logic [PRIO_BITS-1:0] in_pri;
    logic                 in_slot_ok;

    logic [PRIO_BITS-1:0] ent_pri;
    logic [TIME_BITS-1:0] ent_rem;
    logic [TIME_BITS-1:0] ent_burst;
    logic [TIME_BITS-1:0] ent_arr;
    logic                 ent_cand;
    logic                 ent_better;

    logic [TIME_BITS-1:0] time_inc;
    logic [TIME_BITS-1:0] res_wt;

    assign in_slot    = s_tdata[SLOT_BITS-1:0];
    assign in_arr     = s_tdata[SLOT_BITS +: TIME_BITS];
    assign in_burst   = s_tdata[SLOT_BITS + TIME_BITS +: TIME_BITS];
    assign in_pri     = s_tdata[SLOT_BITS + 2 * TIME_BITS +: PRIO_BITS];
    assign in_slot_ok = 32'(in_slot) < MAX_TASKS;
    assign in_fire    = s_tvalid && s_tready;
    assign scan_last  = scan_cnt_reg == CNT_W'(MAX_TASKS);

    assign ent_pri    = rd_data_reg[PRIO_BITS-1:0];
    assign ent_rem    = rd_data_reg[PRIO_BITS +: TIME_BITS];
    assign ent_burst  = rd_data_reg[PRIO_BITS + TIME_BITS +: TIME_BITS];
    assign ent_arr    = rd_data_reg[PRIO_BITS + 2 * TIME_BITS +: TIME_BITS];
    assign ent_cand   = valid_reg[rd_idx_reg] && (ent_rem != '0);
    assign ent_better = !found_reg || (ent_pri < best_pri_reg)
                        || ((ent_pri == best_pri_reg) && (ent_arr < best_arr_reg));

    assign time_inc   = (time_reg == TIME_MAX) ? time_reg : time_reg + TIME_BITS'(1);
    assign res_wt     = (res_fin_reg && (res_tat_reg >= best_burst_reg))
                        ? res_tat_reg - best_burst_reg : '0;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = (s_tuser == OP_TICK) ? ST_SCAN : ST_FIN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = best_idx_reg;
        mem_wdata = {best_arr_reg, best_burst_reg, best_rem_reg - TIME_BITS'(1), best_pri_reg};
        mem_raddr = scan_cnt_reg[SLOT_W-1:0];
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                mem_we    = in_fire && (s_tuser == OP_LOAD) && in_slot_ok;
                mem_waddr = SLOT_W'(in_slot);
                mem_wdata = {in_arr, in_burst, in_burst, in_pri};
            end
            ST_SCAN: begin
            end
            ST_EXEC: begin
                mem_we = pending_reg && found_reg;
            end
            ST_FIN: begin
                out_load = !m_tvalid_reg || m_tready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
        rd_idx_reg  <= mem_raddr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            time_reg     <= '0;
            scan_cnt_reg <= '0;
            pending_reg  <= 1'b0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    scan_cnt_reg <= '0;
                    pending_reg  <= 1'b0;
                    found_reg    <= 1'b0;
                    if (in_fire && (s_tuser == OP_LOAD) && in_slot_ok) begin
                        valid_reg[SLOT_W'(in_slot)] <= 1'b1;
                    end
                end
                ST_SCAN: begin
                    scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
                    if ((scan_cnt_reg != '0) && ent_cand) begin
                        pending_reg <= 1'b1;
                        if ((ent_arr <= time_reg) && ent_better) begin
                            found_reg <= 1'b1;
                        end
                    end
                end
                ST_EXEC: begin
                    if (pending_reg) begin
                        time_reg <= time_inc;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                res_kind_reg <= KIND_LOAD;
                res_slot_reg <= '0;
                res_tick_reg <= '0;
                res_fin_reg  <= 1'b0;
                res_ct_reg   <= '0;
                res_tat_reg  <= '0;
            end
            ST_SCAN: begin
                if ((scan_cnt_reg != '0) && ent_cand && (ent_arr <= time_reg) && ent_better)
                begin
                    best_idx_reg   <= rd_idx_reg;
                    best_pri_reg   <= ent_pri;
                    best_arr_reg   <= ent_arr;
                    best_burst_reg <= ent_burst;
                    best_rem_reg   <= ent_rem;
                end
            end
            ST_EXEC: begin
                res_tick_reg <= time_reg;
                if (!pending_reg) begin
                    res_kind_reg <= KIND_DONE;
                end else if (!found_reg) begin
                    res_kind_reg <= KIND_IDLE;
                end else begin
                    res_kind_reg <= KIND_RAN;
                    res_slot_reg <= SLOT_BITS'(best_idx_reg);
                    if (best_rem_reg == TIME_BITS'(1)) begin
                        res_fin_reg <= 1'b1;
                        res_ct_reg  <= time_inc;
                        res_tat_reg <= (time_inc >= best_arr_reg)
                                       ? time_inc - best_arr_reg : '0;
                    end
                end
            end
            ST_FIN: begin
                if (out_load) begin
                    m_tuser_reg <= res_kind_reg;
                    m_tdata_reg <= M_DATA_W'({res_wt, res_tat_reg, res_ct_reg, res_fin_reg,
                                              res_tick_reg, res_slot_reg});
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
`default_nettype wire

[design/pps_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pps_checker
// Port-level checks of the scheduler's transaction stream.
// ----------------------------------------------------------------------------
module pps_checker #(
    parameter int TIME_BITS = pps_pkg::TIME_BITS_DEF,
    parameter int M_DATA_W  = 72
) (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_tvalid,
    input wire logic                         s_tready,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [M_DATA_W-1:0]          m_tdata,
    input wire logic [pps_pkg::KIND_BITS-1:0] m_tuser
);

    import pps_pkg::*;

    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    logic [SLOT_BITS-1:0] out_slot;
    logic [TIME_BITS-1:0] out_tick;
    logic                 out_fin;
    logic [TIME_BITS-1:0] out_ct;
    logic [TIME_BITS-1:0] out_tat;
    logic [TIME_BITS-1:0] out_wt;
    logic [TIME_BITS-1:0] tick_inc;

    assign out_slot = m_tdata[SLOT_BITS-1:0];
    assign out_tick = m_tdata[SLOT_BITS +: TIME_BITS];
    assign out_fin  = m_tdata[SLOT_BITS + TIME_BITS];
    assign out_ct   = m_tdata[SLOT_BITS + 1 + TIME_BITS +: TIME_BITS];
    assign out_tat  = m_tdata[SLOT_BITS + 1 + 2 * TIME_BITS +: TIME_BITS];
    assign out_wt   = m_tdata[SLOT_BITS + 1 + 3 * TIME_BITS +: TIME_BITS];
    assign tick_inc = (out_tick == TIME_MAX) ? out_tick : out_tick + TIME_BITS'(1);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Result transaction changed while stalled.");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("Input accepted while a transaction is still in progress.");

    a_completion: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_RAN) && out_fin |-> out_ct == tick_inc)
        else $error("Completion time does not follow the tick start.");

    a_quiet_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != KIND_RAN) |-> !out_fin && (out_slot == '0)
                                              && (out_ct == '0))
        else $error("Result without a running task carries task fields.");

    a_wait_le_tat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> out_wt <= out_tat)
        else $error("Waiting time exceeds turnaround.");

endmodule

bind preemptive_priority_scheduler_top pps_checker #(
    .TIME_BITS (TIME_BITS),
    .M_DATA_W  (M_DATA_W)
) u_pps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the preemptive priority scheduler. A directed table
// covers reset, zero bursts, idle time, preemption, tie breaks, reloads and
// field extremes. Randomized episodes of task loads and ticks follow, and a
// final phase clears the table. Every result transaction is compared field by
// field against an in-bench model of the task table (directed rows give the kind
// and tick start themselves), with random gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb_top;
    import pps_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int TW         = TIME_BITS_DEF;
    localparam int NSLOT      = MAX_TASKS_DEF;
    localparam int S_DW       = ((SLOT_BITS + 2 * TW + PRIO_BITS + 7) / 8) * 8;
    localparam int M_DW       = ((SLOT_BITS + 1 + 4 * TW + 7) / 8) * 8;
    localparam int RAND_ITEMS = 800;
    localparam int DIR_N      = 26;
    localparam logic [TW-1:0] TIME_MAX = {TW{1'b1}};

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [SLOT_BITS-1:0] chosen_slot;
        logic [TW-1:0]        tick_start;
        logic                 finished;
        logic [TW-1:0]        completion;
        logic [TW-1:0]        turnaround;
        logic [TW-1:0]        waiting;
    } outcome_t;

    typedef struct packed {
        logic                 op;
        logic [SLOT_BITS-1:0] slot;
        logic [TW-1:0]        arrival;
        logic [TW-1:0]        burst;
        logic [PRIO_BITS-1:0] prio;
        logic                 typed;
        logic [KIND_BITS-1:0] kind;
        logic [TW-1:0]        tick_start;
    } dir_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DW-1:0]      s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DW-1:0]      m_tdata;
    logic [KIND_BITS-1:0] m_tuser;

    logic                 task_valid  [NSLOT];
    logic [TW-1:0]        task_arr    [NSLOT];
    logic [TW-1:0]        task_burst  [NSLOT];
    logic [TW-1:0]        task_rem    [NSLOT];
    logic [PRIO_BITS-1:0] task_prio   [NSLOT];
    logic [TW-1:0]        sched_now;

    outcome_t outcomes [$];
    dir_row_t dir_tbl [DIR_N];
    bit       calm;
    int       mismatches;
    int       sent, received, n_ran, n_fin, n_idle, n_done;

    preemptive_priority_scheduler_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic logic [TW-1:0] sat_inc(logic [TW-1:0] t);
        return (t == TIME_MAX) ? t : t + 1'b1;
    endfunction

    function automatic bit work_left();
        for (int k = 0; k < NSLOT; k++) begin
            if (task_valid[k] && task_rem[k] != 0) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic outcome_t schedule_step(logic op, logic [SLOT_BITS-1:0] slot,
                                               logic [TW-1:0] arr, logic [TW-1:0] burst,
                                               logic [PRIO_BITS-1:0] prio);
        outcome_t r;
        bit pending;
        bit found;
        int best;
        r = '0;
        pending = 1'b0;
        found = 1'b0;
        best = 0;
        if (op == OP_LOAD) begin
            task_valid[slot] = 1'b1;
            task_arr[slot]   = arr;
            task_burst[slot] = burst;
            task_rem[slot]   = burst;
            task_prio[slot]  = prio;
            r.kind = KIND_LOAD;
            return r;
        end
        for (int k = 0; k < NSLOT; k++) begin
            if (task_valid[k] && task_rem[k] != 0) begin
                pending = 1'b1;
                if (task_arr[k] <= sched_now) begin
                    if (!found || task_prio[k] < task_prio[best]
                        || (task_prio[k] == task_prio[best] && task_arr[k] < task_arr[best])) begin
                        best = k;
                        found = 1'b1;
                    end
                end
            end
        end
        r.tick_start = sched_now;
        if (!pending) begin
            r.kind = KIND_DONE;
            return r;
        end
        sched_now = sat_inc(sched_now);
        if (!found) begin
            r.kind = KIND_IDLE;
            return r;
        end
        r.kind = KIND_RAN;
        r.chosen_slot = best[SLOT_BITS-1:0];
        task_rem[best] = task_rem[best] - 1'b1;
        if (task_rem[best] == 0) begin
            r.finished   = 1'b1;
            r.completion = sched_now;
            r.turnaround = (sched_now >= task_arr[best]) ? sched_now - task_arr[best] : '0;
            r.waiting    = (r.turnaround >= task_burst[best])
                           ? r.turnaround - task_burst[best] : '0;
        end
        return r;
    endfunction

    function automatic dir_row_t mk_row(logic op, int slot, int arr, int burst, int prio,
                                        int typed, logic [KIND_BITS-1:0] kind, int ts);
        dir_row_t d;
        d.op = op;
        d.slot = slot[SLOT_BITS-1:0];
        d.arrival = arr[TW-1:0];
        d.burst = burst[TW-1:0];
        d.prio = prio[PRIO_BITS-1:0];
        d.typed = (typed != 0);
        d.kind = kind;
        d.tick_start = ts[TW-1:0];
        return d;
    endfunction

    task automatic send_item(logic op, logic [SLOT_BITS-1:0] slot, logic [TW-1:0] arr,
                             logic [TW-1:0] burst, logic [PRIO_BITS-1:0] prio,
                             logic typed, outcome_t typed_out);
        int gap;
        outcome_t r;
        gap = calm ? 0 : $urandom_range(0, 9);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_DW'({prio, burst, arr, slot});
        do @(posedge aclk); while (!s_tready);
        r = schedule_step(op, slot, arr, burst, prio);
        outcomes.push_back(typed ? typed_out : r);
        sent++;
    endtask

    task automatic send_plain(logic op, logic [SLOT_BITS-1:0] slot, logic [TW-1:0] arr,
                              logic [TW-1:0] burst, logic [PRIO_BITS-1:0] prio);
        send_item(op, slot, arr, burst, prio, 1'b0, '0);
    endtask

    task automatic chk_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    initial begin
        int n;
        outcome_t e;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            n = calm ? 0 : $urandom_range(0, 9);
            @(negedge aclk);
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            received++;
            if (outcomes.size() == 0) begin
                $error("result transaction arrived with no outcome pending");
                mismatches++;
            end else begin
                e = outcomes.pop_front();
                chk_field("kind", 32'(e.kind), 32'(m_tuser));
                chk_field("chosen_slot", 32'(e.chosen_slot), 32'(m_tdata[0 +: SLOT_BITS]));
                chk_field("tick_start", 32'(e.tick_start), 32'(m_tdata[SLOT_BITS +: TW]));
                chk_field("finished", 32'(e.finished), 32'(m_tdata[SLOT_BITS + TW]));
                chk_field("finish_time", 32'(e.completion),
                          32'(m_tdata[SLOT_BITS + TW + 1 +: TW]));
                chk_field("turnaround", 32'(e.turnaround),
                          32'(m_tdata[SLOT_BITS + 2 * TW + 1 +: TW]));
                chk_field("waiting", 32'(e.waiting),
                          32'(m_tdata[SLOT_BITS + 3 * TW + 1 +: TW]));
            end
            case (m_tuser)
                KIND_RAN: begin
                    n_ran++;
                    if (m_tdata[SLOT_BITS + TW]) n_fin++;
                end
                KIND_IDLE: n_idle++;
                KIND_DONE: n_done++;
                default: ;
            endcase
        end
    end

    initial begin
        #(150_000_000);
        $display("FAIL");
        $finish;
    end

    initial begin
        int i, k, nt, ticks, cnt;
        outcome_t t;
        logic [TW-1:0] a, b;
        logic [PRIO_BITS-1:0] p;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_LOAD;
        calm = 1'b0;
        mismatches = 0;
        sent = 0;
        received = 0;
        n_ran = 0;
        n_fin = 0;
        n_idle = 0;
        n_done = 0;
        sched_now = '0;
        for (k = 0; k < NSLOT; k++) begin
            task_valid[k] = 1'b0;
            task_arr[k]   = '0;
            task_burst[k] = '0;
            task_rem[k]   = '0;
            task_prio[k]  = '0;
        end

        dir_tbl[0]  = mk_row(OP_TICK, 0, 0, 0, 0, 1, KIND_DONE, 0);
        dir_tbl[1]  = mk_row(OP_LOAD, 0, 0, 0, 0, 1, KIND_LOAD, 0);
        dir_tbl[2]  = mk_row(OP_TICK, 0, 0, 0, 0, 1, KIND_DONE, 0);
        dir_tbl[3]  = mk_row(OP_LOAD, 15, 3, 2, 255, 1, KIND_LOAD, 0);
        dir_tbl[4]  = mk_row(OP_TICK, 0, 0, 0, 0, 1, KIND_IDLE, 0);
        dir_tbl[5]  = mk_row(OP_TICK, 0, 0, 0, 0, 1, KIND_IDLE, 1);
        dir_tbl[6]  = mk_row(OP_TICK, 0, 0, 0, 0, 1, KIND_IDLE, 2);
        dir_tbl[7]  = mk_row(OP_TICK, 0, 0, 0, 0, 0, KIND_LOAD, 0);
        dir_tbl[8]  = mk_row(OP_LOAD, 1, 0, 3, 0, 1, KIND_LOAD, 0);
        dir_tbl[9]  = mk_row(OP_LOAD, 2, 0, 1, 0, 1, KIND_LOAD, 0);
        dir_tbl[10] = mk_row(OP_LOAD, 7, 65535, 65535, 0, 1, KIND_LOAD, 0);
        dir_tbl[11] = mk_row(OP_TICK, 0, 0, 0, 0, 0, KIND_LOAD, 0);
        dir_tbl[12] = mk_row(OP_LOAD, 4, 2, 1, 5, 1, KIND_LOAD, 0);
        dir_tbl[13] = mk_row(OP_LOAD, 3, 3, 1, 5, 1, KIND_LOAD, 0);
        dir_tbl[14] = mk_row(OP_TICK, 0, 0, 0, 0, 0, KIND_LOAD, 0);
        dir_tbl[15] = mk_row(OP_TICK, 0, 0, 0, 0, 0, KIND_LOAD, 0);
        dir_tbl[16] = mk_row(OP_TICK, 0, 0, 0, 0, 0, KIND_LOAD, 0);
        dir_tbl[17] = mk_row(OP_TICK, 0, 0, 0, 0, 0, KIND_LOAD, 0);
        dir_tbl[18] = mk_row(OP_TICK, 0, 0, 0, 0, 0, KIND_LOAD, 0);
        dir_tbl[19] = mk_row(OP_TICK, 0, 0, 0, 0, 0, KIND_LOAD, 0);
        dir_tbl[20] = mk_row(OP_LOAD, 1, 0, 2, 128, 1, KIND_LOAD, 0);
        dir_tbl[21] = mk_row(OP_LOAD, 7, 0, 0, 255, 1, KIND_LOAD, 0);
        dir_tbl[22] = mk_row(OP_TICK, 0, 0, 0, 0, 0, KIND_LOAD, 0);
        dir_tbl[23] = mk_row(OP_TICK, 0, 0, 0, 0, 0, KIND_LOAD, 0);
        dir_tbl[24] = mk_row(OP_TICK, 0, 0, 0, 0, 0, KIND_LOAD, 0);
        dir_tbl[25] = mk_row(OP_TICK, 0, 0, 0, 0, 0, KIND_LOAD, 0);

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < DIR_N; i++) begin
            t = '0;
            t.kind = dir_tbl[i].kind;
            t.tick_start = dir_tbl[i].tick_start;
            send_item(dir_tbl[i].op, dir_tbl[i].slot, dir_tbl[i].arrival, dir_tbl[i].burst,
                      dir_tbl[i].prio, dir_tbl[i].typed, t);
        end

        // Episodes: sometimes zero all slots, load 1 to 4 tasks mostly near the current time, then tick.
        while (sent < DIR_N + RAND_ITEMS) begin
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 5) == 0) begin
                for (k = 0; k < NSLOT; k++) begin
                    send_plain(OP_LOAD, k[SLOT_BITS-1:0], TW'($urandom_range(0, 65535)), '0,
                               PRIO_BITS'($urandom_range(0, 255)));
                end
            end
            nt = $urandom_range(1, 4);
            for (k = 0; k < nt; k++) begin
                if ($urandom_range(0, 7) == 0) begin
                    a = TW'($urandom_range(0, 65535));
                    b = TW'($urandom_range(0, 65535));
                    p = PRIO_BITS'($urandom_range(0, 255));
                end else begin
                    a = sched_now + TW'($urandom_range(0, 6)) - TW'(3);
                    b = TW'($urandom_range(0, 5));
                    p = PRIO_BITS'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                        : $urandom_range(0, 255));
                end
                send_plain(OP_LOAD, SLOT_BITS'($urandom_range(0, 15)), a, b, p);
            end
            if ($urandom_range(0, 3) == 0) begin
                cnt = 0;
                while (work_left() && cnt < 40) begin
                    send_plain(OP_TICK, SLOT_BITS'($urandom_range(0, 15)),
                               TW'($urandom_range(0, 65535)), TW'($urandom_range(0, 65535)),
                               PRIO_BITS'($urandom_range(0, 255)));
                    cnt++;
                end
            end
            ticks = $urandom_range(1, 12);
            for (k = 0; k < ticks; k++) begin
                send_plain(OP_TICK, SLOT_BITS'($urandom_range(0, 15)),
                           TW'($urandom_range(0, 65535)), TW'($urandom_range(0, 65535)),
                           PRIO_BITS'($urandom_range(0, 255)));
            end
        end

        // Clear the table, after which ticks report that all tasks are finished.
        calm = 1'b0;
        for (k = 0; k < NSLOT; k++) begin
            send_plain(OP_LOAD, k[SLOT_BITS-1:0], '0, '0, '0);
        end
        send_plain(OP_TICK, '0, '0, '0, '0);
        send_plain(OP_TICK, '0, '0, '0, '0);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outcomes.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("Sent %0d input transactions and checked %0d results: %0d ran, %0d completed,",
                 sent, received, n_ran, n_fin);
        $display("%0d ticks found the processor idle and %0d found every task finished.",
                 n_idle, n_done);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
